FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the sliding median spike detector
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SMSD_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define SMSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg
// types and fixed constants of the sliding median spike detector
// ----------------------------------------------------------------------------
package smsd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 11;
    localparam int MD_W     = 9;
    localparam int ALERT_W  = 24;

    localparam logic [MD_W-1:0]    MD_SAT    = '1;
    localparam logic [ALERT_W-1:0] ALERT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_INC_RD,
        ST_INC_WR,
        ST_OUT
    } smsd_state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } hist_ctrl_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic restart;
        logic push;
    } ring_ctrl_t;

endpackage

FILE: design/smsd_hist.sv
// ----------------------------------------------------------------------------
// smsd_hist
// histogram memory with per-bin valid bits, one read and one write port
// ----------------------------------------------------------------------------
module smsd_hist import smsd_pkg::*; #(
    parameter int  VALUE_BINS = 256,
    parameter int  WINDOW_MAX = 1024,
    localparam int BIN_W      = $clog2(VALUE_BINS),
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  hist_ctrl_t       ctrl,
    input  logic [BIN_W-1:0] rd_addr,
    input  logic [BIN_W-1:0] wr_addr,
    input  logic [CNT_W-1:0] wr_count,
    output logic [CNT_W-1:0] rd_count
);

    logic [CNT_W-1:0]      mem [VALUE_BINS];
    logic [CNT_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic [VALUE_BINS-1:0] vld_reg;
    logic [VALUE_BINS-1:0] vld_next;

    // a bin never written since the last clear reads as zero
    assign rd_count = rd_vld_reg ? rd_data_reg : '0;

    always_comb begin
        vld_next = vld_reg;
        if (ctrl.clear) begin
            vld_next = '0;
        end else if (ctrl.wr_en) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_count;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

endmodule

FILE: design/smsd_ring.sv
// ----------------------------------------------------------------------------
// smsd_ring
// sample ring with write pointer and fill level, read-first single port
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smsd_ring import smsd_pkg::*; #(
    parameter int  WINDOW_MAX = 1024,
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1),
    localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ring_ctrl_t          ctrl,
    input  logic [LEN_W-1:0]    len,
    input  logic [SAMPLE_W-1:0] push_sample,
    output logic [SAMPLE_W-1:0] old_sample,
    output logic                filling
);

    logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic [LEN_W-1:0]    fill_reg;
    logic [LEN_W-1:0]    fill_next;
    logic [LEN_W-1:0]    ptr_inc;

    assign filling    = fill_reg < len;
    assign old_sample = rd_data_reg;
    assign ptr_inc    = LEN_W'(ptr_reg) + LEN_W'(1);

    always_comb begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (ctrl.restart) begin
            ptr_next  = '0;
            fill_next = '0;
        end else if (ctrl.push) begin
            ptr_next = (ptr_inc >= len) ? '0 : PTR_W'(ptr_inc);
            if (filling) begin
                fill_next = fill_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    // read-first: the displaced sample comes out as the new one goes in
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[ptr_reg] <= push_sample;
            rd_data_reg  <= mem[ptr_reg];
        end
    end

    `SMSD_ASSERT(ap_ptr_in_window, aclk, aresetn, 1'b1, LEN_W'(ptr_reg) < len)
    `SMSD_ASSERT(ap_fill_in_window, aclk, aresetn, 1'b1, fill_reg <= len)

endmodule

FILE: design/smsd_scan.sv
// ----------------------------------------------------------------------------
// smsd_scan
// cumulative histogram scan unit: one bin per step, finds two ranks at once
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smsd_scan import smsd_pkg::*; #(
    parameter int  VALUE_BINS = 256,
    parameter int  WINDOW_MAX = 1024,
    localparam int BIN_W      = $clog2(VALUE_BINS),
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  scan_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [BIN_W-1:0] bin,
    input  logic [CNT_W-1:0] rank_lo,
    input  logic [CNT_W-1:0] rank_hi,
    output logic             done,
    output logic [BIN_W-1:0] v_lo,
    output logic [BIN_W-1:0] v_hi
);

    logic [CNT_W:0]   cum_reg;
    logic [CNT_W:0]   cum_sum;
    logic             f_lo_reg;
    logic             f_hi_reg;
    logic [BIN_W-1:0] v_lo_reg;
    logic [BIN_W-1:0] v_hi_reg;
    logic             hit_lo;
    logic             hit_hi;

    assign cum_sum = cum_reg + (CNT_W + 1)'(count);
    assign hit_lo  = !f_lo_reg && ((CNT_W + 1)'(rank_lo) <= cum_sum);
    assign hit_hi  = !f_hi_reg && ((CNT_W + 1)'(rank_hi) <= cum_sum);
    assign done    = ctrl.step && (f_hi_reg || hit_hi);
    assign v_lo    = v_lo_reg;
    assign v_hi    = v_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_lo_reg <= 1'b0;
            f_hi_reg <= 1'b0;
            cum_reg  <= '0;
        end else if (ctrl.start) begin
            f_lo_reg <= 1'b0;
            f_hi_reg <= 1'b0;
            cum_reg  <= '0;
        end else if (ctrl.step) begin
            cum_reg <= cum_sum;
            if (hit_lo) begin
                f_lo_reg <= 1'b1;
            end
            if (hit_hi) begin
                f_hi_reg <= 1'b1;
            end
        end
    end

    // rank never reached leaves the top bin
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            v_lo_reg <= BIN_W'(VALUE_BINS - 1);
            v_hi_reg <= BIN_W'(VALUE_BINS - 1);
        end else if (ctrl.step) begin
            if (hit_lo) begin
                v_lo_reg <= bin;
            end
            if (hit_hi) begin
                v_hi_reg <= bin;
            end
        end
    end

    `SMSD_ASSERT(ap_hi_after_lo, aclk, aresetn, f_hi_reg, f_lo_reg)
    `SMSD_ASSERT(ap_ranks_ordered, aclk, aresetn, f_hi_reg, v_lo_reg <= v_hi_reg)

endmodule

FILE: design/sliding_median_spike_detect_core.sv
// ----------------------------------------------------------------------------
// sliding_median_spike_detect_core
// sliding-window median spike detector built around a histogram scan unit
// ----------------------------------------------------------------------------
// usage
//   s_valid/s_ready/s_sample carry one 8-bit sample per item. while the window
//   is filling, an item is only stored and gives no result. once full, every
//   item gives one result on m_valid/m_ready: m_alert, m_median_doubled and
//   the saturating alert count m_alert_total.
//   cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, above
//   WINDOW_MAX acts as WINDOW_MAX); a write restarts the window, keeps the
//   alert count; the user issues it only while the block is idle (unchecked).
// sequence
//   a filling item passes through accept, histogram read and histogram write.
//   a full item passes through accept, k scan steps, four histogram update
//   steps and the output load, k being the bins scanned (up to VALUE_BINS,
//   fewer when both median ranks are found early). s_ready is high only
//   between items.
// reset
//   synchronous, active low: window length 1, empty window, count zero.
//   histogram bins are cleared at once through per-bin valid bits.
// stall
//   a result waits in the output register while m_ready is low; the block
//   holds in its output state until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_spike_detect_core import smsd_pkg::*; #(
    parameter int VALUE_BINS = 256,
    parameter int WINDOW_MAX = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    // sample channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_alert,
    output logic [MD_W-1:0]     m_median_doubled,
    output logic [ALERT_W-1:0]  m_alert_total
);

    localparam int BIN_W = $clog2(VALUE_BINS);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(VALUE_BINS - 1);

    // clamp the written length into the supported range
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return LEN_W'(1);
        end
        if (32'(v) > 32'(WINDOW_MAX)) begin
            return LEN_W'(WINDOW_MAX);
        end
        return LEN_W'(v);
    endfunction

    // samples beyond the bins land in the top bin
    function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] v);
        return (32'(v) >= 32'(VALUE_BINS)) ? LAST_BIN : BIN_W'(v);
    endfunction

    smsd_state_t         state_reg, state_next;
    logic [LEN_W-1:0]    len_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                full_reg, full_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_alert_reg;
    logic [MD_W-1:0]     m_md_reg;
    logic [ALERT_W-1:0]  alert_cnt_reg;

    logic                accept;
    logic                load_out;

    hist_ctrl_t          hist_ctrl;
    logic [BIN_W-1:0]    hist_rd_addr;
    logic [BIN_W-1:0]    hist_wr_addr;
    logic [LEN_W-1:0]    hist_wr_count;
    logic [LEN_W-1:0]    hist_rd_count;

    scan_ctrl_t          scan_ctrl;
    logic                scan_done;
    logic [BIN_W-1:0]    v_lo, v_hi;
    logic [LEN_W-1:0]    rank_lo, rank_hi;

    ring_ctrl_t          ring_ctrl;
    logic [SAMPLE_W-1:0] old_sample;
    logic                filling;

    logic [BIN_W:0]      md_sum;
    logic [MD_W-1:0]     md;
    logic                alert;

    // ranks of the middle pair; an odd window uses the same rank twice
    assign rank_hi = (len_reg >> 1) + LEN_W'(1);
    assign rank_lo = len_reg[0] ? rank_hi : (len_reg >> 1);

    assign md_sum = {1'b0, v_lo} + {1'b0, v_hi};
    assign md     = (32'(md_sum) > 32'(MD_SAT)) ? MD_SAT : MD_W'(md_sum);
    assign alert  = MD_W'(sample_reg) >= md;

    assign accept    = s_valid && s_ready;
    assign ring_ctrl = '{restart: cfg_wr_en, push: accept};

    smsd_hist #(
        .VALUE_BINS (VALUE_BINS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (hist_ctrl),
        .rd_addr  (hist_rd_addr),
        .wr_addr  (hist_wr_addr),
        .wr_count (hist_wr_count),
        .rd_count (hist_rd_count)
    );

    smsd_scan #(
        .VALUE_BINS (VALUE_BINS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (scan_ctrl),
        .count   (hist_rd_count),
        .bin     (bin_reg),
        .rank_lo (rank_lo),
        .rank_hi (rank_hi),
        .done    (scan_done),
        .v_lo    (v_lo),
        .v_hi    (v_hi)
    );

    smsd_ring #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ring_ctrl),
        .len         (len_reg),
        .push_sample (s_sample),
        .old_sample  (old_sample),
        .filling     (filling)
    );

    // sequencer: scan, drop the oldest sample, add the new one, deliver; while filling, only add
    always_comb begin
        state_next      = state_reg;
        full_next       = full_reg;
        bin_next        = bin_reg;
        s_ready         = 1'b0;
        load_out        = 1'b0;
        scan_ctrl.start = 1'b0;
        scan_ctrl.step  = 1'b0;
        hist_ctrl.clear = cfg_wr_en;
        hist_ctrl.wr_en = 1'b0;
        hist_rd_addr    = '0;
        hist_wr_addr    = bin_of(sample_reg);
        hist_wr_count   = hist_rd_count + LEN_W'(1);
        case (state_reg)
            ST_IDLE: begin
                // bin 0 is read every idle cycle to prime the scan
                s_ready = 1'b1;
                if (s_valid) begin
                    scan_ctrl.start = 1'b1;
                    bin_next        = '0;
                    full_next       = !filling;
                    state_next      = filling ? ST_INC_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // data of bin_reg arrives now, next bin is requested
                scan_ctrl.step = 1'b1;
                hist_rd_addr   = (bin_reg == LAST_BIN) ? bin_reg : bin_reg + BIN_W'(1);
                bin_next       = bin_reg + BIN_W'(1);
                if (scan_done || bin_reg == LAST_BIN) begin
                    state_next = ST_DEC_RD;
                end
            end
            ST_DEC_RD: begin
                hist_rd_addr = bin_of(old_sample);
                state_next   = ST_DEC_WR;
            end
            ST_DEC_WR: begin
                hist_ctrl.wr_en = 1'b1;
                hist_wr_addr    = bin_of(old_sample);
                hist_wr_count   = (hist_rd_count != '0) ? hist_rd_count - LEN_W'(1)
                                                        : hist_rd_count;
                state_next      = ST_INC_RD;
            end
            ST_INC_RD: begin
                hist_rd_addr = bin_of(sample_reg);
                state_next   = ST_INC_WR;
            end
            ST_INC_WR: begin
                hist_ctrl.wr_en = 1'b1;
                state_next      = full_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            full_reg  <= 1'b0;
            bin_reg   <= '0;
            len_reg   <= LEN_W'(1);
        end else begin
            state_reg <= state_next;
            full_reg  <= full_next;
            bin_reg   <= bin_next;
            if (cfg_wr_en) begin
                len_reg <= eff_len(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
    end

    // output register and alert count
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            alert_cnt_reg <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (load_out && alert && alert_cnt_reg != ALERT_MAX) begin
                alert_cnt_reg <= alert_cnt_reg + ALERT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_alert_reg <= alert;
            m_md_reg    <= md;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_alert          = m_alert_reg;
    assign m_median_doubled = m_md_reg;
    assign m_alert_total    = alert_cnt_reg;

    `SMSD_ASSERT_NEXT(ap_busy_after_accept, aclk, aresetn, accept, !s_ready)
    `SMSD_ASSERT_NEXT(ap_out_waits, aclk, aresetn,
        state_reg == ST_OUT && m_valid_reg && !m_ready, state_reg == ST_OUT)
    `SMSD_ASSERT_NEXT(ap_count_monotonic, aclk, aresetn, 1'b1,
        alert_cnt_reg >= $past(alert_cnt_reg))

endmodule
